// ===== rtl/lpfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpfd_pkg;

   localparam int LPFD_QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_SIZE_CODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_MODE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_LENGTH = 2'd2;

   localparam logic [1:0]  RST_LENGTH_SIZE_CODE = 2'd2;
   localparam logic        RST_LENGTH_MODE      = 1'b0;
   localparam logic [63:0] RST_MAX_FRAME_LENGTH = 64'd65536;

   localparam logic [1:0] ST_PAYLOAD = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_EXCEED  = 2'd3;

   localparam logic MODE_PAYLOAD_ONLY = 1'b0;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_STALLED = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_of_frame;
      logic [1:0] status;
   } rsp_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [3:0] prefix_size(input logic [1:0] code);
      logic [3:0] size;
      case (code)
         2'd0:    size = 4'd1;
         2'd1:    size = 4'd2;
         2'd2:    size = 4'd4;
         default: size = 4'd8;
      endcase
      return size;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/length_prefix_frame_decoder.sv =====
// Length-prefixed frame decoder.
// req_*: one stream byte per word (req_in_byte). A word is taken on a clock
//   edge with req_valid high and req_stall low; a new byte may follow every
//   cycle while req_stall is low: a sustained rate of one byte per cycle.
// rsp_*: zero or one result word per byte: a payload byte with its
//   end-of-frame flag, an empty-frame marker, or an error status. The result
//   of a byte is written into the queue and then into the output register:
//   the front parser classifies the byte in the cycle it is offered and
//   writes its result into the queue on the accepting edge; it moves on into
//   the output register after older results, once that register is free.
// csr_*: write-only registers (prefix size code, length mode, maximum frame
//   length); the user must write only while the block is idle (unenforced).
// Reset: registers return to a 4-byte prefix, payload-only mode and a
//   maximum of 65536; the parser waits for a prefix and the queue empties.
// When rsp_stall is held the output register keeps its word and the queue
//   fills; req_stall rises once QUEUE_DEPTH results are waiting.
// After an error result all later bytes are taken and dropped until reset.
`timescale 1ns / 1ps
`default_nettype none

module length_prefix_frame_decoder #(
   parameter int QUEUE_DEPTH = lpfd_pkg::LPFD_QUEUE_DEPTH
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [7:0]                       req_in_byte,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [7:0]                       rsp_payload_byte,
   output logic                             rsp_last_of_frame,
   output logic [1:0]                       rsp_status,
   input  wire                              csr_wr_en,
   input  wire  [lpfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [lpfd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lpfd_pkg::*;

   logic             accept;
   logic             push;
   rsp_word_type     push_word;
   logic             pop;
   rsp_word_type     pop_word;
   queue_status_type q_status;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   lpfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push),
      .push_word (push_word)
   );

   lpfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .status    (q_status)
   );

   lpfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .pop_word          (pop_word),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_status        (rsp_status)
   );

`ifndef SYNTHESIS
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !q_status.empty) |=> rsp_valid)
      else $error("queued result not moved to output register");

   a_nonpayload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_PAYLOAD) |-> (rsp_payload_byte == 8'd0))
      else $error("nonzero byte on a non-payload result");

   a_error_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_INVALID || rsp_status == ST_EXCEED))
      |-> !rsp_last_of_frame)
      else $error("error result flagged as end of frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/lpfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpfd_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 accept,
   input  wire  [7:0]                          in_byte,
   input  wire                                 csr_wr_en,
   input  wire  [lpfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [lpfd_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                push,
   output lpfd_pkg::rsp_word_type              push_word
);
   import lpfd_pkg::*;

   logic [1:0]  size_code_ff;
   logic        mode_ff;
   logic [63:0] max_ff;

   phase_type   phase_ff, phase_in;
   logic [2:0]  seen_ff, seen_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] remain_ff, remain_in;

   logic [3:0]  size;
   logic [63:0] size64;
   logic [3:0]  seen_inc;
   logic [63:0] acc_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_code_ff <= RST_LENGTH_SIZE_CODE;
         mode_ff      <= RST_LENGTH_MODE;
         max_ff       <= RST_MAX_FRAME_LENGTH;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LENGTH_SIZE_CODE: size_code_ff <= csr_data[1:0];
            CSR_LENGTH_MODE:      mode_ff      <= csr_data[0];
            CSR_MAX_FRAME_LENGTH: max_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         seen_ff   <= 3'd0;
         acc_ff    <= 64'd0;
         remain_ff <= 64'd0;
      end else begin
         phase_ff  <= phase_in;
         seen_ff   <= seen_in;
         acc_ff    <= acc_in;
         remain_ff <= remain_in;
      end
   end

   assign size     = prefix_size(size_code_ff);
   assign size64   = {60'd0, size};
   assign seen_inc = {1'b0, seen_ff} + 4'd1;
   assign acc_new  = {acc_ff[55:0], in_byte};

   always_comb begin
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      acc_in    = acc_ff;
      remain_in = remain_ff;
      push      = 1'b0;
      push_word = '{payload_byte: 8'd0, last_of_frame: 1'b0, status: ST_PAYLOAD};
      if (accept) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               push                   = 1'b1;
               push_word.payload_byte = in_byte;
               remain_in              = remain_ff - 64'd1;
               if (remain_ff == 64'd1) begin
                  push_word.last_of_frame = 1'b1;
                  phase_in                = PH_HEADER;
                  seen_in                 = 3'd0;
                  acc_in                  = 64'd0;
                  remain_in               = 64'd0;
               end
            end
            PH_HEADER: begin
               acc_in = acc_new;
               if (seen_inc < size) begin
                  seen_in = seen_inc[2:0];
               end else begin
                  seen_in = 3'd0;
                  acc_in  = 64'd0;
                  if (mode_ff == MODE_PAYLOAD_ONLY) begin
                     if ((max_ff < size64) || (acc_new > (max_ff - size64))) begin
                        push             = 1'b1;
                        push_word.status = ST_EXCEED;
                        phase_in         = PH_STALLED;
                     end else if (acc_new == 64'd0) begin
                        push                    = 1'b1;
                        push_word.status        = ST_EMPTY;
                        push_word.last_of_frame = 1'b1;
                     end else begin
                        phase_in  = PH_PAYLOAD;
                        remain_in = acc_new;
                     end
                  end else begin
                     if (acc_new < size64) begin
                        push             = 1'b1;
                        push_word.status = ST_INVALID;
                        phase_in         = PH_STALLED;
                     end else if (acc_new > max_ff) begin
                        push             = 1'b1;
                        push_word.status = ST_EXCEED;
                        phase_in         = PH_STALLED;
                     end else if (acc_new == size64) begin
                        push                    = 1'b1;
                        push_word.status        = ST_EMPTY;
                        push_word.last_of_frame = 1'b1;
                     end else begin
                        phase_in  = PH_PAYLOAD;
                        remain_in = acc_new - size64;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lpfd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpfd_queue #(
   parameter int DEPTH = lpfd_pkg::LPFD_QUEUE_DEPTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  lpfd_pkg::rsp_word_type     push_word,
   input  wire                        pop,
   output lpfd_pkg::rsp_word_type     pop_word,
   output lpfd_pkg::queue_status_type status
);
   import lpfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_word_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign pop_word     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/lpfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpfd_back (
   input  wire                        clock,
   input  wire                        reset,
   input  lpfd_pkg::queue_status_type q_status,
   input  lpfd_pkg::rsp_word_type     pop_word,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [7:0]                 rsp_payload_byte,
   output logic                       rsp_last_of_frame,
   output logic [1:0]                 rsp_status
);
   import lpfd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   assign pop      = !q_status.empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         word_ff <= pop_word;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_payload_byte  = word_ff.payload_byte;
   assign rsp_last_of_frame = word_ff.last_of_frame;
   assign rsp_status        = word_ff.status;

endmodule

`default_nettype wire
